>>> src/c3rb_pkg.sv
package c3rb_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int MAX_HEIGHT_DEFAULT = 1024;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int KERNEL_W   = 3 * COEF_W;
    localparam int CFG_DATA_W = KERNEL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int SIZE_W     = 11;
    localparam int COLUMN_W   = 3 * PIX_W;
    localparam int PROD_W     = COEF_W + PIX_W + 1;
    localparam int RESULT_W   = 28;

    localparam int QUEUE_DEPTH = 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_TOP    = 3'd0,
        REG_KERNEL_MIDDLE = 3'd1,
        REG_KERNEL_BOTTOM = 3'd2,
        REG_IMAGE_WIDTH   = 3'd3,
        REG_IMAGE_HEIGHT  = 3'd4
    } reg_index_t;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic                       run_last;
        logic                       frame_last;
    } result_t;

    function automatic logic signed [COEF_W-1:0] coef(
        input logic [KERNEL_W-1:0] row,
        input int                  col
    );
        return $signed(row[col*COEF_W +: COEF_W]);
    endfunction

endpackage

>>> src/conv3x3_replicate_border_core.sv
// Streaming 3x3 convolution with replicated borders.
// Input channel (in_valid/in_ready): one beat per pixel in raster order
// (opcode pixel), then image_width drain beats (opcode drain) after the last
// pixel of a frame to flush the bottom row. A drain beat inside a frame and
// a pixel beat during the flush are taken and give nothing.
// Output channel (out_valid/out_ready): filtered_value with run_last on the
// last result of an input beat and frame_last on the bottom-right pixel.
// Configuration: cfg_write with cfg_index/cfg_data writes one register per
// cycle; write only while the block is idle.
// Throughput: one input beat per cycle while out_ready stays high; a row-end
// beat gives two results, which the result queue absorbs. The input stalls
// only when the receiver stalls and the queued and in-flight results near QUEUE_DEPTH.
// A taken beat's first result passes the window, product and row-sum registers
// and the queue; a second result appears in the cycle after the first is taken.
// When the receiver stalls, results wait in the queue and in_ready drops
// once the queue could not absorb a new beat's results.
// Reset clears positions, the window, the queue and the kernel, sets both sizes
// to 1024; the line store holds no valid data until a frame writes it.
module conv3x3_replicate_border_core
    import c3rb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       opcode,
    input  logic [PIX_W-1:0]           pixel,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [RESULT_W-1:0] filtered_value,
    output logic                       run_last,
    output logic                       frame_last
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int WC_W = ($clog2(MAX_WIDTH + 1) > SIZE_W) ? $clog2(MAX_WIDTH + 1) : SIZE_W;
    localparam int HC_W = (RW > SIZE_W) ? RW : SIZE_W;
    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int SUM_W = QW + 3;

    logic [KERNEL_W-1:0] kernel_reg [3];
    logic [SIZE_W-1:0]   image_width_reg;
    logic [SIZE_W-1:0]   image_height_reg;

    logic [AW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic                draining_reg, draining_next;
    logic [COLUMN_W-1:0] window_reg [3];
    logic [COLUMN_W-1:0] window_next [3];

    logic [WC_W-1:0]     width_ext, w_eff;
    logic [HC_W-1:0]     height_ext, h_eff, row_inc;
    logic                rowend, last_row, act, emit;

    logic [2*PIX_W-1:0]  line_rd;
    logic [PIX_W-1:0]    older_px, newer_px, top_px, bot_px;
    logic [COLUMN_W-1:0] column;

    logic                s1_a_reg, s1_b_reg, s1_frame_reg;
    logic                s2_a_reg, s2_b_reg, s2_frame_reg;
    logic                s3_a_reg, s3_b_reg, s3_frame_reg;

    logic signed [PROD_W-1:0]   prod_a_next [3][3];
    logic signed [PROD_W-1:0]   prod_b_next [3][3];
    logic signed [PROD_W-1:0]   prod_a_reg  [3][3];
    logic signed [PROD_W-1:0]   prod_b_reg  [3][3];
    logic signed [RESULT_W-1:0] row_a_next  [3];
    logic signed [RESULT_W-1:0] row_b_next  [3];
    logic signed [RESULT_W-1:0] row_a_reg   [3];
    logic signed [RESULT_W-1:0] row_b_reg   [3];

    result_t             res_a, res_b, push_first, queue_out;
    logic [1:0]          push_n;
    logic [QW:0]         queue_count;
    logic [SUM_W-1:0]    pending;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg[0]    <= '0;
            kernel_reg[1]    <= '0;
            kernel_reg[2]    <= '0;
            image_width_reg  <= SIZE_RESET;
            image_height_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KERNEL_TOP:    kernel_reg[0]    <= cfg_data;
                REG_KERNEL_MIDDLE: kernel_reg[1]    <= cfg_data;
                REG_KERNEL_BOTTOM: kernel_reg[2]    <= cfg_data;
                REG_IMAGE_WIDTH:   image_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg <= cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    // clamp sizes
    always_comb
    begin
        width_ext  = WC_W'(image_width_reg);
        height_ext = HC_W'(image_height_reg);
        if (width_ext == '0)
        begin
            w_eff = WC_W'(1);
        end
        else if (width_ext > WC_W'(MAX_WIDTH))
        begin
            w_eff = WC_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_ext;
        end
        if (height_ext == '0)
        begin
            h_eff = HC_W'(1);
        end
        else if (height_ext > HC_W'(MAX_HEIGHT))
        begin
            h_eff = HC_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_ext;
        end
    end

    assign pending  = SUM_W'(queue_count) + SUM_W'(s1_a_reg) + SUM_W'(s1_b_reg)
                    + SUM_W'(s2_a_reg) + SUM_W'(s2_b_reg)
                    + SUM_W'(s3_a_reg) + SUM_W'(s3_b_reg);
    assign in_ready = (pending <= SUM_W'(QUEUE_DEPTH - 2));
    assign act      = in_valid && in_ready && ((opcode == OP_DRAIN) == draining_reg);

    assign rowend   = (WC_W'(col_reg) + WC_W'(1)) >= w_eff;
    assign row_inc  = HC_W'(row_reg) + HC_W'(1);
    assign last_row = row_inc >= h_eff;
    assign emit     = draining_reg || (row_reg != '0);

    c3rb_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIX_W)
    ) u_line_store (
        .clk        (clk),
        .write_en   (act && !draining_reg),
        .write_addr (col_reg),
        .write_data ({newer_px, pixel}),
        .read_addr  (col_next),
        .read_data  (line_rd)
    );

    // assemble the new column from the stored rows and the input, or the stored rows alone while draining
    always_comb
    begin
        older_px = line_rd[2*PIX_W-1:PIX_W];
        newer_px = line_rd[PIX_W-1:0];
        top_px   = (row_reg > RW'(1)) ? older_px : newer_px;
        bot_px   = draining_reg ? newer_px : pixel;
        column   = {bot_px, newer_px, top_px};
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        draining_next  = draining_reg;
        window_next[0] = window_reg[0];
        window_next[1] = window_reg[1];
        window_next[2] = window_reg[2];
        if (act)
        begin
            if (col_reg == '0)
            begin
                window_next[0] = column;
                window_next[1] = column;
                window_next[2] = column;
            end
            else
            begin
                window_next[0] = window_reg[1];
                window_next[1] = window_reg[2];
                window_next[2] = column;
            end
            if (rowend)
            begin
                col_next = '0;
                if (draining_reg)
                begin
                    row_next      = '0;
                    draining_next = 1'b0;
                end
                else if (last_row)
                begin
                    row_next      = RW'(h_eff);
                    draining_next = 1'b1;
                end
                else
                begin
                    row_next = RW'(row_inc);
                end
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            draining_reg  <= 1'b0;
            window_reg[0] <= '0;
            window_reg[1] <= '0;
            window_reg[2] <= '0;
            s1_a_reg      <= 1'b0;
            s1_b_reg      <= 1'b0;
            s1_frame_reg  <= 1'b0;
            s2_a_reg      <= 1'b0;
            s2_b_reg      <= 1'b0;
            s2_frame_reg  <= 1'b0;
            s3_a_reg      <= 1'b0;
            s3_b_reg      <= 1'b0;
            s3_frame_reg  <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            draining_reg  <= draining_next;
            window_reg[0] <= window_next[0];
            window_reg[1] <= window_next[1];
            window_reg[2] <= window_next[2];
            s1_a_reg      <= act && emit && (col_reg != '0);
            s1_b_reg      <= act && emit && rowend;
            s1_frame_reg  <= draining_reg;
            s2_a_reg      <= s1_a_reg;
            s2_b_reg      <= s1_b_reg;
            s2_frame_reg  <= s1_frame_reg;
            s3_a_reg      <= s2_a_reg;
            s3_b_reg      <= s2_b_reg;
            s3_frame_reg  <= s2_frame_reg;
        end
    end

    // multiply: result A uses columns 0,1,2; result B uses columns 1,2,2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_a_next[i][j] = PROD_W'(coef(kernel_reg[i], j))
                    * PROD_W'($signed({1'b0, window_reg[j][i*PIX_W +: PIX_W]}));
                prod_b_next[i][j] = PROD_W'(coef(kernel_reg[i], j))
                    * PROD_W'($signed({1'b0, window_reg[(j == 0) ? 1 : 2][i*PIX_W +: PIX_W]}));
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            row_a_next[i] = RESULT_W'(prod_a_reg[i][0]) + RESULT_W'(prod_a_reg[i][1])
                          + RESULT_W'(prod_a_reg[i][2]);
            row_b_next[i] = RESULT_W'(prod_b_reg[i][0]) + RESULT_W'(prod_b_reg[i][1])
                          + RESULT_W'(prod_b_reg[i][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        row_a_reg  <= row_a_next;
        row_b_reg  <= row_b_next;
    end

    always_comb
    begin
        res_a.value      = row_a_reg[0] + row_a_reg[1] + row_a_reg[2];
        res_a.run_last   = !s3_b_reg;
        res_a.frame_last = 1'b0;
        res_b.value      = row_b_reg[0] + row_b_reg[1] + row_b_reg[2];
        res_b.run_last   = 1'b1;
        res_b.frame_last = s3_frame_reg;
        push_first       = s3_a_reg ? res_a : res_b;
        push_n           = 2'(s3_a_reg) + 2'(s3_b_reg);
    end

    c3rb_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_n      (push_n),
        .push_first  (push_first),
        .push_second (res_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (queue_out),
        .count       (queue_count)
    );

    assign filtered_value = queue_out.value;
    assign run_last       = queue_out.run_last;
    assign frame_last     = queue_out.frame_last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (QW+1)'(queue_count) <= (QW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> run_last)
        else $error("frame_last without run_last");

    a_stray_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode == OP_DRAIN) && !draining_reg)
        |=> (!s1_a_reg && !s1_b_reg && $stable(col_reg) && $stable(row_reg)))
        else $error("drain beat inside a frame changed state");

    a_flush_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(draining_reg) |-> (row_reg == '0 && col_reg == '0))
        else $error("flush end did not restart the frame");
`endif

endmodule

>>> src/c3rb_line_store.sv
module c3rb_line_store
    import c3rb_pkg::*;
#(
    parameter int DEPTH  = MAX_WIDTH_DEFAULT,
    parameter int DATA_W = 2 * PIX_W
) (
    input  logic                     clk,
    input  logic                     write_en,
    input  logic [$clog2(DEPTH)-1:0] write_addr,
    input  logic [DATA_W-1:0]        write_data,
    input  logic [$clog2(DEPTH)-1:0] read_addr,
    output logic [DATA_W-1:0]        read_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] read_data_reg;

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mem[write_addr] <= write_data;
        end
    end

    // forward a same-cycle write so the next beat sees it
    always_ff @(posedge clk)
    begin
        if (write_en && (write_addr == read_addr))
        begin
            read_data_reg <= write_data;
        end
        else
        begin
            read_data_reg <= mem[read_addr];
        end
    end

    assign read_data = read_data_reg;

endmodule

>>> src/c3rb_result_queue.sv
module c3rb_result_queue
    import c3rb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [1:0]               push_n,
    input  result_t                  push_first,
    input  result_t                  push_second,
    output logic                     out_valid,
    input  logic                     out_ready,
    output result_t                  out_data,
    output logic [$clog2(DEPTH):0]   count
);

    localparam int PW = $clog2(DEPTH);

    result_t        mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    logic           pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push_n) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_reg + PW'(1)] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
